// ===== hdl/btr_pkg.sv =====
// ----------------------------------------------------------------------------
// btr_pkg : shared definitions for the binary to radix digit converter
// Defaults for the top level parameters, digit width and the radix reset value.
// ----------------------------------------------------------------------------
package btr_pkg;

   localparam int VALUE_BITS_DEFAULT        = 128;
   localparam int DIGITS_PER_RESULT_DEFAULT = 8;

   localparam int DIGIT_W     = 8;
   localparam int RADIX_W     = 8;
   localparam int GROUP_W     = 64;
   localparam int GROUP_BYTES = GROUP_W / DIGIT_W;
   localparam int COUNT_W     = 4;
   localparam int TOTAL_W     = 8;

   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);

endpackage

// ===== hdl/btr_byte_div.sv =====
// ----------------------------------------------------------------------------
// btr_byte_div : one byte of restoring long division by the radix
// Shifts eight dividend bits into the running remainder, one compare and
// subtract per bit, and gives the quotient byte and the new remainder.
// ----------------------------------------------------------------------------
module btr_byte_div
   import btr_pkg::*;
(
   input  logic [RADIX_W-1:0] rem_i,
   input  logic [DIGIT_W-1:0] dividend_i,
   input  logic [RADIX_W-1:0] radix_i,
   output logic [DIGIT_W-1:0] quotient_o,
   output logic [RADIX_W-1:0] rem_o
);

   always_comb begin
      logic [RADIX_W:0]   trial;
      logic [RADIX_W-1:0] rem;
      rem        = rem_i;
      quotient_o = '0;
      // remainder stays below the radix, so the trial value fits in 9 bits
      for (int b = DIGIT_W - 1; b >= 0; b--) begin
         trial = {rem, dividend_i[b]};
         if (trial >= {1'b0, radix_i}) begin
            trial         = trial - {1'b0, radix_i};
            quotient_o[b] = 1'b1;
         end
         rem = trial[RADIX_W-1:0];
      end
      rem_o = rem;
   end

endmodule

// ===== hdl/binary_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// binary_to_radix_digits : unsigned binary value to digits in radix 2..255
// Divides the value by the radix one byte per cycle, stacks the remainders
// and sends them most significant first, packed into digit groups.
// ----------------------------------------------------------------------------
//
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  req     | req_valid/req_stall, value hi/lo    | in
//  rsp     | rsp_valid/rsp_stall, group fields   | out
//  csr     | csr_write_enable, csr_write_data    | in
//
// Each digit takes one pass over the active bytes in the byte divider; active
// bytes start at ceil(VALUE_BITS/8) and drop by one whenever the quotient's
// top byte clears. Each digit is then read from the stack memory through a
// registered read port, and each group is held until rsp_stall is low.
// req_stall is high from the transfer of a value until its last group is
// taken. A radix below two takes the value and produces no groups.
// Reset is synchronous and sets the radix to ten.
// ----------------------------------------------------------------------------
module binary_to_radix_digits
   import btr_pkg::*;
#(
   parameter int VALUE_BITS        = VALUE_BITS_DEFAULT,
   parameter int DIGITS_PER_RESULT = DIGITS_PER_RESULT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [RADIX_W-1:0] csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [63:0]        req_value_high,
   input  logic [63:0]        req_value_low,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [GROUP_W-1:0] rsp_digit_group,
   output logic [COUNT_W-1:0] rsp_group_count,
   output logic [TOTAL_W-1:0] rsp_total_digits,
   output logic               rsp_last
);

   localparam int NBYTES      = (VALUE_BITS + DIGIT_W - 1) / DIGIT_W;
   localparam int WORK_W      = NBYTES * DIGIT_W;
   localparam int BIDX_W      = $clog2(NBYTES);
   localparam int STACK_DEPTH = VALUE_BITS;
   localparam int SIDX_W      = $clog2(STACK_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_NEXT,
      ST_FETCH,
      ST_PLACE,
      ST_OUT
   } state_type;

   state_type                          state_ff, state_in;
   logic [RADIX_W-1:0]                 radix_ff, radix_in;
   logic [NBYTES-1:0][DIGIT_W-1:0]     work_ff, work_in;
   logic [BIDX_W:0]                    nb_ff, nb_in;
   logic [BIDX_W-1:0]                  idx_ff, idx_in;
   logic [RADIX_W-1:0]                 rem_ff, rem_in;
   logic                               top_zero_ff, top_zero_in;
   logic [TOTAL_W-1:0]                 n_ff, n_in;
   logic [TOTAL_W-1:0]                 pos_ff, pos_in;
   logic [GROUP_BYTES-1:0][DIGIT_W-1:0] group_ff, group_in;
   logic [COUNT_W-1:0]                 cnt_ff, cnt_in;
   logic                               last_ff, last_in;

   logic [DIGIT_W-1:0] stack_mem [STACK_DEPTH];
   logic [DIGIT_W-1:0] rd_data_ff;
   logic [SIDX_W-1:0]  rd_idx;
   logic               stk_we;

   logic [127:0]       value_full;
   logic [DIGIT_W-1:0] quotient;
   logic [RADIX_W-1:0] rem_next;
   logic               at_top;
   logic               top_zero_now;

   assign value_full = {req_value_high, req_value_low};
   assign rd_idx     = SIDX_W'(n_ff - TOTAL_W'(1) - pos_ff);
   assign at_top     = ({1'b0, idx_ff} == (BIDX_W + 1)'(nb_ff - 1'b1));

   btr_byte_div u_byte_div (
      .rem_i      (rem_ff),
      .dividend_i (work_ff[idx_ff]),
      .radix_i    (radix_ff),
      .quotient_o (quotient),
      .rem_o      (rem_next)
   );

   assign top_zero_now = at_top ? (quotient == '0) : top_zero_ff;

   always_comb begin
      state_in    = state_ff;
      radix_in    = radix_ff;
      work_in     = work_ff;
      nb_in       = nb_ff;
      idx_in      = idx_ff;
      rem_in      = rem_ff;
      top_zero_in = top_zero_ff;
      n_in        = n_ff;
      pos_in      = pos_ff;
      group_in    = group_ff;
      cnt_in      = cnt_ff;
      last_in     = last_ff;
      stk_we      = 1'b0;

      if (csr_write_enable) begin
         radix_in = csr_write_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (radix_ff >= RADIX_MIN)) begin
               work_in     = WORK_W'(value_full[VALUE_BITS-1:0]);
               nb_in       = (BIDX_W + 1)'(NBYTES);
               idx_in      = BIDX_W'(NBYTES - 1);
               rem_in      = '0;
               top_zero_in = 1'b0;
               n_in        = '0;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            work_in[idx_ff] = quotient;
            top_zero_in     = top_zero_now;
            if (idx_ff == '0) begin
               // push the remainder as the next digit, least significant first
               stk_we = 1'b1;
               n_in   = n_ff + TOTAL_W'(1);
               rem_in = '0;
               if (top_zero_now && (nb_ff > (BIDX_W + 1)'(1))) begin
                  nb_in = nb_ff - 1'b1;
               end
               state_in = ST_NEXT;
            end else begin
               idx_in = idx_ff - 1'b1;
               rem_in = rem_next;
            end
         end
         ST_NEXT: begin
            if (work_ff == '0) begin
               pos_in   = '0;
               cnt_in   = '0;
               group_in = '0;
               state_in = ST_FETCH;
            end else begin
               idx_in      = BIDX_W'(nb_ff - 1'b1);
               top_zero_in = 1'b0;
               state_in    = ST_DIV;
            end
         end
         ST_FETCH: begin
            state_in = ST_PLACE;
         end
         ST_PLACE: begin
            group_in[3'(GROUP_BYTES - 1) - cnt_ff[2:0]] = rd_data_ff;
            cnt_in  = cnt_ff + COUNT_W'(1);
            pos_in  = pos_ff + TOTAL_W'(1);
            last_in = (pos_ff + TOTAL_W'(1) == n_ff);
            if ((cnt_ff + COUNT_W'(1) == COUNT_W'(DIGITS_PER_RESULT)) ||
                (pos_ff + TOTAL_W'(1) == n_ff)) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_OUT: begin
            // hold the group until the transfer completes
            if (!rsp_stall) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  group_in = '0;
                  cnt_in   = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_RESET;
         work_ff  <= '0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         radix_ff <= radix_in;
         work_ff  <= work_in;
         n_ff     <= n_in;
      end
      nb_ff       <= nb_in;
      idx_ff      <= idx_in;
      rem_ff      <= rem_in;
      top_zero_ff <= top_zero_in;
      pos_ff      <= pos_in;
      group_ff    <= group_in;
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[n_ff[SIDX_W-1:0]] <= rem_next;
      end
      rd_data_ff <= stack_mem[rd_idx];
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_OUT);
   assign rsp_digit_group  = group_ff;
   assign rsp_group_count  = cnt_ff;
   assign rsp_total_digits = n_ff;
   assign rsp_last         = last_ff;

endmodule
